/* hdl/ipv4rc_pkg.sv */
// shared types, codes and local-range constants for the ipv4 range classifier
`default_nettype none

package ipv4rc_pkg;

    // table slot field width and the number of slots it can reach
    localparam int ENTRY_W    = 5;
    localparam int SLOT_COUNT = 1 << ENTRY_W;
    localparam int COUNT_W    = 6;

    typedef enum logic [1:0] {
        OP_LOOKUP      = 2'd0,
        OP_WRITE_RANGE = 2'd1,
        OP_WRITE_KNOWN = 2'd2
    } opcode_t;

    typedef enum logic {
        CFG_RANGES_IN_USE     = 1'b0,
        CFG_WELL_KNOWN_IN_USE = 1'b1
    } cfg_index_t;

    localparam logic [2:0] CLASS_LOCAL      = 3'd0;
    localparam logic [2:0] CLASS_WELL_KNOWN = 3'd1;
    localparam logic [2:0] CLASS_RANGE      = 3'd2;
    localparam logic [2:0] CLASS_INVALID    = 3'd3;
    localparam logic [2:0] CLASS_UNKNOWN    = 3'd4;

    localparam logic [7:0]  LOOPBACK_NET = 8'h7F;
    localparam logic [31:0] PRIV10_LO    = 32'h0A00_0000;
    localparam logic [31:0] PRIV10_HI    = 32'h0AFF_FFFF;
    localparam logic [31:0] PRIV172_LO   = 32'hAC10_0000;
    localparam logic [31:0] PRIV172_HI   = 32'hAC1F_FFFF;
    localparam logic [31:0] PRIV192_LO   = 32'hC0A8_0000;
    localparam logic [31:0] PRIV192_HI   = 32'hC0A8_FFFF;
    localparam logic [31:0] LINKLOC_LO   = 32'hA9FE_0000;
    localparam logic [31:0] LINKLOC_HI   = 32'hA9FE_FFFF;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        address;
        logic [ENTRY_W-1:0] entry_index;
        logic [31:0]        range_start;
        logic [31:0]        range_end;
        logic [7:0]         country_code;
        logic [7:0]         org_code;
        logic [7:0]         service_code;
    } req_t;

    typedef struct packed {
        logic [2:0]         match_class;
        logic [7:0]         result_service;
        logic [7:0]         result_country;
        logic [7:0]         result_org;
        logic [ENTRY_W-1:0] match_index;
    } rsp_t;

    // loopback, private and link-local ranges
    function automatic logic is_local(input logic [31:0] a);
        logic r;
        r = (a[31:24] == LOOPBACK_NET)
            || (a >= PRIV10_LO  && a <= PRIV10_HI)
            || (a >= PRIV172_LO && a <= PRIV172_HI)
            || (a >= PRIV192_LO && a <= PRIV192_HI)
            || (a >= LINKLOC_LO && a <= LINKLOC_HI);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/ipv4_range_classifier_top.sv */
// ipv4 range classifier: pipelined local / well-known / range lookup
// each request passes through stage registers 0 .. LAST and then the response register,
//   with LAST = max($clog2(min(RANGE_ENTRIES,32)+1), 2)
// throughput: one word per cycle; a held response stalls the whole pipeline
// each binary-search level owns one pipeline stage and its own copy of the range table
// reset: pipeline valids, response valid and both count registers clear; tables are
//   undefined until written and get no clearing pass
`default_nettype none

module ipv4_range_classifier_top
    import ipv4rc_pkg::*;
#(
    parameter int RANGE_ENTRIES = 32,
    parameter int KNOWN_ENTRIES = 32
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request channel
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_t       req,
    // response channel
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_t            rsp,
    // configuration writes
    input  wire logic       cfg_write,
    input  wire cfg_index_t cfg_index,
    input  wire logic [COUNT_W-1:0] cfg_data
);

    // only slots reachable by the entry index field are stored
    localparam int RANGE_DEPTH = (RANGE_ENTRIES < SLOT_COUNT) ? RANGE_ENTRIES : SLOT_COUNT;
    localparam int KNOWN_DEPTH = (KNOWN_ENTRIES < SLOT_COUNT) ? KNOWN_ENTRIES : SLOT_COUNT;
    localparam int RIW    = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
    localparam int KIW    = (KNOWN_DEPTH > 1) ? $clog2(KNOWN_DEPTH) : 1;
    localparam int RCW    = $clog2(RANGE_DEPTH + 1);
    localparam int KCW    = $clog2(KNOWN_DEPTH + 1);
    // one search level per stage; at least two stages for the service read
    localparam int LEVELS = RCW;
    localparam int LAST   = (LEVELS > 2) ? LEVELS : 2;

    typedef struct packed {
        logic                   valid;
        req_t                   item;
        logic                   is_local;
        logic                   is_zero;
        logic [KNOWN_DEPTH-1:0] known_hit;
        logic                   known_found;
        logic [KIW-1:0]         known_idx;
        logic [7:0]             service;
        logic [RCW-1:0]         lo;        // search window, lo inclusive
        logic [RCW-1:0]         hi;        // hi exclusive
        logic [RIW-1:0]         mid;
        logic                   range_found;
        logic [RIW-1:0]         range_idx;
        logic [7:0]             country;
        logic [7:0]             org;
    } stage_t;

    // midpoint of the inclusive window lo .. hi-1
    function automatic logic [RIW-1:0] mid_of(input logic [RCW-1:0] lo,
                                              input logic [RCW-1:0] hi);
        logic [RCW:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} - {{RCW{1'b0}}, 1'b1};
        return RIW'(sum >> 1);
    endfunction

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [COUNT_W-1:0] ranges_in_use_reg;
    logic [COUNT_W-1:0] well_known_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ranges_in_use_reg     <= '0;
            well_known_in_use_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RANGES_IN_USE:     ranges_in_use_reg     <= cfg_data;
                CFG_WELL_KNOWN_IN_USE: well_known_in_use_reg <= cfg_data;
            endcase
        end
    end

    // counts saturated to the stored table depth
    logic [RCW-1:0] range_count;
    logic [KCW-1:0] known_count;

    assign range_count = (ranges_in_use_reg > COUNT_W'(RANGE_DEPTH))
                       ? RCW'(RANGE_DEPTH) : RCW'(ranges_in_use_reg);
    assign known_count = (well_known_in_use_reg > COUNT_W'(KNOWN_DEPTH))
                       ? KCW'(KNOWN_DEPTH) : KCW'(well_known_in_use_reg);

    // ---------------------------------------------------------------
    // pipeline control: the whole pipe moves together
    // ---------------------------------------------------------------
    logic   advance;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    rsp_t   rsp_reg;
    rsp_t   rsp_next;
    stage_t st_reg     [0:LAST];
    stage_t stage_next [0:LAST+1];

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // entry into stage zero
    always_comb
    begin
        stage_next[0]       = '0;
        stage_next[0].valid = req_valid;
        stage_next[0].item  = req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                st_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                st_reg[k] <= stage_next[k];
            end
        end
    end

    // write strobes, each taken where its table copy is read
    logic range_slot_ok [0:LAST];
    logic known_slot_ok [0:LAST];

    always_comb
    begin
        for (int k = 0; k <= LAST; k++)
        begin
            range_slot_ok[k] = advance && st_reg[k].valid
                && (st_reg[k].item.opcode == OP_WRITE_RANGE)
                && ({1'b0, st_reg[k].item.entry_index} < COUNT_W'(RANGE_DEPTH));
            known_slot_ok[k] = advance && st_reg[k].valid
                && (st_reg[k].item.opcode == OP_WRITE_KNOWN)
                && ({1'b0, st_reg[k].item.entry_index} < COUNT_W'(KNOWN_DEPTH));
        end
    end

    // ---------------------------------------------------------------
    // well-known address table: flip-flops compared in parallel in stage 0
    // ---------------------------------------------------------------
    logic [31:0] known_addr_reg [KNOWN_DEPTH];

    always_ff @(posedge clk)
    begin
        if (known_slot_ok[0])
        begin
            known_addr_reg[KIW'(st_reg[0].item.entry_index)] <= st_reg[0].item.address;
        end
    end

    // service table: written in stage 1, read at the winning slot from stage 1
    logic [7:0] svc_mem [KNOWN_DEPTH];
    logic [7:0] svc_rd_reg;

    always_ff @(posedge clk)
    begin
        if (known_slot_ok[1])
        begin
            svc_mem[KIW'(st_reg[1].item.entry_index)] <= st_reg[1].item.service_code;
        end
        if (advance)
        begin
            svc_rd_reg <= svc_mem[stage_next[2].known_idx];
        end
    end

    // ---------------------------------------------------------------
    // range table copies, one per search level
    // level g is addressed from stage g and compared in stage g+1
    // ---------------------------------------------------------------
    logic [31:0] rd_start_reg [1:LEVELS];
    logic [31:0] rd_end_reg   [1:LEVELS];
    logic [7:0]  rd_cty_reg   [1:LEVELS];
    logic [7:0]  rd_org_reg   [1:LEVELS];

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        logic [31:0] start_mem [RANGE_DEPTH];
        logic [31:0] end_mem   [RANGE_DEPTH];
        logic [7:0]  cty_mem   [RANGE_DEPTH];
        logic [7:0]  org_mem   [RANGE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (range_slot_ok[g])
            begin
                start_mem[RIW'(st_reg[g].item.entry_index)] <= st_reg[g].item.range_start;
                end_mem[RIW'(st_reg[g].item.entry_index)]   <= st_reg[g].item.range_end;
                cty_mem[RIW'(st_reg[g].item.entry_index)]   <= st_reg[g].item.country_code;
                org_mem[RIW'(st_reg[g].item.entry_index)]   <= st_reg[g].item.org_code;
            end
            if (advance)
            begin
                rd_start_reg[g+1] <= start_mem[stage_next[g+1].mid];
                rd_end_reg[g+1]   <= end_mem[stage_next[g+1].mid];
                rd_cty_reg[g+1]   <= cty_mem[stage_next[g+1].mid];
                rd_org_reg[g+1]   <= org_mem[stage_next[g+1].mid];
            end
        end
    end

    // ---------------------------------------------------------------
    // per-stage work
    // ---------------------------------------------------------------
    for (genvar g = 0; g <= LAST; g++)
    begin : g_stage
        stage_t pre;

        // fixed checks, known-table match, priority pick, service capture
        always_comb
        begin
            pre = st_reg[g];
            if (g == 0)
            begin
                pre.is_local = is_local(pre.item.address);
                pre.is_zero  = (pre.item.address == 32'd0);
                for (int i = 0; i < KNOWN_DEPTH; i++)
                begin
                    pre.known_hit[i] = (KCW'(i) < known_count)
                                    && (known_addr_reg[i] == pre.item.address);
                end
                pre.lo          = '0;
                pre.hi          = range_count;
                pre.range_found = 1'b0;
            end
            if (g == 1)
            begin
                pre.known_found = 1'b0;
                pre.known_idx   = '0;
                // lowest matching slot wins
                for (int i = KNOWN_DEPTH - 1; i >= 0; i--)
                begin
                    if (pre.known_hit[i])
                    begin
                        pre.known_found = 1'b1;
                        pre.known_idx   = KIW'(i);
                    end
                end
            end
            if (g == 2)
            begin
                pre.service = svc_rd_reg;
            end
        end

        if (g >= 1 && g <= LEVELS)
        begin : g_cmp
            // one binary-search probe against the word read last cycle
            always_comb
            begin
                stage_next[g+1] = pre;
                if (!pre.range_found && (pre.lo < pre.hi))
                begin
                    priority if (pre.item.address >= rd_start_reg[g]
                                 && pre.item.address <= rd_end_reg[g])
                    begin
                        stage_next[g+1].range_found = 1'b1;
                        stage_next[g+1].range_idx   = pre.mid;
                        stage_next[g+1].country     = rd_cty_reg[g];
                        stage_next[g+1].org         = rd_org_reg[g];
                    end
                    else if (pre.item.address < rd_start_reg[g])
                    begin
                        stage_next[g+1].hi = RCW'(pre.mid);
                    end
                    else
                    begin
                        stage_next[g+1].lo = RCW'(pre.mid) + RCW'(1);
                    end
                end
                stage_next[g+1].mid = mid_of(stage_next[g+1].lo, stage_next[g+1].hi);
            end
        end
        else
        begin : g_pass
            always_comb
            begin
                stage_next[g+1]     = pre;
                stage_next[g+1].mid = mid_of(pre.lo, pre.hi);
            end
        end
    end

    // ---------------------------------------------------------------
    // result assembly, in check order, into the output register
    // ---------------------------------------------------------------
    always_comb
    begin
        rsp_valid_next = stage_next[LAST+1].valid
                      && (stage_next[LAST+1].item.opcode == OP_LOOKUP);
        rsp_next       = '0;
        priority if (stage_next[LAST+1].is_local)
        begin
            rsp_next.match_class = CLASS_LOCAL;
        end
        else if (stage_next[LAST+1].known_found)
        begin
            rsp_next.match_class    = CLASS_WELL_KNOWN;
            rsp_next.result_service = stage_next[LAST+1].service;
            rsp_next.match_index    = ENTRY_W'(stage_next[LAST+1].known_idx);
        end
        else if (stage_next[LAST+1].is_zero)
        begin
            rsp_next.match_class = CLASS_INVALID;
        end
        else if (stage_next[LAST+1].range_found)
        begin
            rsp_next.match_class    = CLASS_RANGE;
            rsp_next.result_country = stage_next[LAST+1].country;
            rsp_next.result_org     = stage_next[LAST+1].org;
            rsp_next.match_index    = ENTRY_W'(stage_next[LAST+1].range_idx);
        end
        else
        begin
            rsp_next.match_class = CLASS_UNKNOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire
